FILE: rtl/core/tpsc_pkg.sv
// Shared types and constants for the two-point scale calibrator.
// Used by the top level and by the shared restoring divider; no dependencies.
`timescale 1ns / 1ps

package tpsc_pkg;

  // Converter samples are unsigned fractions of 16 bits.
  localparam int SMP_W  = 16;
  // References hold 18-bit fractions (65536 means 1.0).
  localparam int REF_W  = 18;
  // Running sample sum.
  localparam int SUM_W  = 32;
  // Signed Q15.8 weights.
  localparam int W_BITS = 24;

  // Shared divider: 33-bit dividend, 18-bit divisor, one quotient bit per cycle.
  localparam int DVD_W  = 33;
  localparam int DVS_W  = 18;
  localparam int STEP_W = $clog2(DVD_W + 1);

  // Width of the smoothing accumulator 9*f + w.
  localparam int ACC_W  = W_BITS + 5;

  // Division by ten as a multiplication: floor(x / 10) equals (x * ceil(2^30 / 10)) >> 30
  // for every x below 2^30 / 6, which covers the smoothing numerator (below 10 * 2^23).
  localparam int RECIP_W      = 27;
  localparam int TENTH_SHIFT  = 30;
  localparam int TENTH_PROD_W = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] TENTH_RECIP = 27'd107374183;

  // 100 grams in Q15.8.
  localparam int SCALE_GRAMS = 25600;

  localparam logic [REF_W-1:0] ZERO_REF_RST = 18'd65536;
  localparam logic [REF_W-1:0] FULL_REF_RST = 18'd131072;

  localparam logic signed [W_BITS-1:0] W_MAX = 24'sh7FFFFF;
  localparam logic signed [W_BITS-1:0] W_MIN = 24'sh800000;
  localparam logic [DVD_W-1:0] MAG_POS_MAX   = 33'd8388607;
  localparam logic [DVD_W-1:0] MAG_NEG_MAX   = 33'd8388608;

  typedef enum logic [1:0] {
    MODE_MEASURE,
    MODE_ZERO_CAL,
    MODE_WAIT,
    MODE_FULL_CAL
  } mode_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: rtl/core/tpsc_divider.sv
// Restoring unsigned divider producing one quotient bit per cycle.
// Depends on tpsc_pkg for widths and the request structure.
`timescale 1ns / 1ps

module tpsc_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tpsc_pkg::div_req_t        req,
  output logic                      done,
  output logic [tpsc_pkg::DVD_W-1:0] quotient
);
  import tpsc_pkg::*;

  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    cand;
  logic [DVS_W:0]    cand_sub;
  logic              fits;

  // Bring down the next dividend bit and try the subtraction.
  assign cand     = {rem_r, quo_r[DVD_W-1]};
  assign cand_sub = cand - {1'b0, dvs_r};
  assign fits     = cand >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        cnt_r  <= STEP_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? cand_sub[DVS_W-1:0] : cand[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/core/two_point_scale_calibrator.sv
// A tick that only changes mode, accumulates or raises the divide guard goes from acceptance
// straight to ST_OUT; a calibration release with samples runs one 33-step division of sum
// by count; a weighing runs a 33-step scaling division on the shared divider, then the
// smoothing by a reciprocal multiplication. One item is in flight at a time; the next is
// accepted once the result has entered the output register. Reset is synchronous and active
// low: measure mode, references 1.0 and 2.0, and sum, count, smoothed weight and out_valid cleared.
`timescale 1ns / 1ps

module two_point_scale_calibrator #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel: one item per tick.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_button_pressed,
  input  logic [15:0]        in_sample,
  // Result channel: one item per input item.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_mode,
  output logic signed [23:0] out_weight_raw,
  output logic signed [23:0] out_weight_smoothed,
  output logic               out_measured,
  output logic               out_saturated,
  output logic               out_divide_guard
);
  import tpsc_pkg::*;

  // The sequencer walks calibration releases and weighings through the shared divider. Mode changes and the
  // accumulation of samples complete at acceptance; a calibration release runs one divider
  // pass, and a weighing runs one divider pass followed by the smoothing step. The result then
  // waits in ST_OUT until the output register is free.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_RAW,
    ST_SMOOTH,
    ST_TENTH,
    ST_DIV_AVG,
    ST_OUT
  } state_t;

  localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;

  state_t                    state_r;
  mode_t                     mode_r;
  logic [REF_W-1:0]          zero_ref_r;
  logic [REF_W-1:0]          full_ref_r;
  logic [SUM_W-1:0]          sum_r;
  logic [COUNT_BITS-1:0]     count_r;
  logic signed [W_BITS-1:0]  smooth_r;

  // Result being built for the current item.
  logic signed [W_BITS-1:0]  raw_r;
  logic                      sat_r;
  logic                      meas_r;
  logic                      guard_r;

  // Operands kept across the steps of a measurement.
  logic [SMP_W-1:0]          samp_r;
  logic [REF_W-1:0]          den_mag_r;
  logic                      den_neg_r;
  logic                      q_neg_r;
  logic                      acc_neg_r;
  logic [ACC_W-1:0]          acc_mag_r;

  // Output register.
  logic                      out_valid_r;
  logic [1:0]                out_mode_r;
  logic signed [W_BITS-1:0]  out_raw_r;
  logic signed [W_BITS-1:0]  out_smooth_r;
  logic                      out_meas_r;
  logic                      out_sat_r;
  logic                      out_guard_r;

  logic                      in_take;
  logic                      out_free;
  logic [SMP_W-1:0]          s_scaled;
  logic signed [REF_W:0]     den;
  logic                      den_zero;
  logic                      den_neg;
  logic [REF_W-1:0]          den_mag;
  logic signed [REF_W:0]     diff;
  logic                      diff_neg;
  logic [REF_W-1:0]          diff_mag;
  logic [DVD_W-1:0]          num_mag;
  logic signed [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]          acc_mag;
  logic signed [W_BITS-1:0]  raw_clip;
  logic                      raw_sat;
  logic [TENTH_PROD_W-1:0]   tenth_prod;
  logic [W_BITS-1:0]         tenth_q;
  logic signed [W_BITS-1:0]  smooth_q;
  logic                      avg_start;

  div_req_t                  div_req;
  logic                      div_done;
  logic [DVD_W-1:0]          div_quo;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Shifting in a 16-bit context drops the sample bits above SAMPLE_BITS and scales the rest
  // to a 16-bit fraction.
  assign s_scaled = in_sample << (SMP_W - SAMPLE_BITS);

  // Span between the two references, as sign and magnitude.
  assign den      = $signed({1'b0, full_ref_r}) - $signed({1'b0, zero_ref_r});
  assign den_zero = (full_ref_r == zero_ref_r);
  assign den_neg  = den[REF_W];
  assign den_mag  = den_neg ? REF_W'(-den) : den[REF_W-1:0];

  // Offset of the sample from the zero reference, scaled to grams in Q15.8.
  assign diff     = $signed({{(REF_W+1-SMP_W){1'b0}}, samp_r}) - $signed({1'b0, zero_ref_r});
  assign diff_neg = diff[REF_W];
  assign diff_mag = diff_neg ? REF_W'(-diff) : diff[REF_W-1:0];
  assign num_mag  = DVD_W'(diff_mag) * DVD_W'(SCALE_GRAMS);

  // Smoothing numerator 9*f + w; its magnitude stays below 10 * 2^23.
  assign acc      = (ACC_W'(smooth_r) <<< 3) + ACC_W'(smooth_r) + ACC_W'(raw_r);
  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // Restore the sign of the scaling quotient and clip it to the Q15.8 range.
  always_comb begin
    raw_sat  = 1'b0;
    raw_clip = W_BITS'(div_quo);
    if (q_neg_r) begin
      if (div_quo > MAG_NEG_MAX) begin
        raw_sat  = 1'b1;
        raw_clip = W_MIN;
      end else begin
        raw_clip = W_BITS'(-div_quo);
      end
    end else if (div_quo > MAG_POS_MAX) begin
      raw_sat  = 1'b1;
      raw_clip = W_MAX;
    end
  end

  // The registered numerator magnitude is divided by ten through its reciprocal, and the sign
  // is put back afterwards so that the result truncates toward zero. The quotient never
  // exceeds the Q15.8 range.
  assign tenth_prod = TENTH_PROD_W'(acc_mag_r) * TENTH_PROD_W'(TENTH_RECIP);
  assign tenth_q    = tenth_prod[TENTH_SHIFT +: W_BITS];
  assign smooth_q   = acc_neg_r ? W_BITS'(-tenth_q) : tenth_q;

  // A calibration release with at least one sample starts the averaging division at once.
  assign avg_start = in_take && !in_button_pressed && (count_r != '0) &&
                     (mode_r == MODE_ZERO_CAL || mode_r == MODE_FULL_CAL);

  always_comb begin
    div_req          = '0;
    div_req.dividend = DVD_W'(sum_r);
    div_req.divisor  = DVS_W'(count_r);
    unique case (state_r)
      ST_IDLE: begin
        div_req.start = avg_start;
      end
      ST_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_mag;
        div_req.divisor  = den_mag_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  tpsc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_MEASURE;
      zero_ref_r  <= ZERO_REF_RST;
      full_ref_r  <= FULL_REF_RST;
      sum_r       <= '0;
      count_r     <= '0;
      smooth_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A result taken while the next one is ready is replaced in ST_OUT below.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            raw_r     <= '0;
            sat_r     <= 1'b0;
            meas_r    <= 1'b0;
            guard_r   <= 1'b0;
            samp_r    <= s_scaled;
            den_mag_r <= den_mag;
            den_neg_r <= den_neg;
            state_r   <= ST_OUT;
            unique case (mode_r)
              MODE_MEASURE: begin
                if (in_button_pressed) begin
                  mode_r  <= MODE_ZERO_CAL;
                  sum_r   <= '0;
                  count_r <= '0;
                end else if (den_zero) begin
                  guard_r <= 1'b1;
                end else begin
                  state_r <= ST_MUL;
                end
              end
              MODE_ZERO_CAL, MODE_FULL_CAL: begin
                if (in_button_pressed) begin
                  // A full count ignores further samples so the average stays honest.
                  if (count_r != CNT_FULL) begin
                    sum_r   <= sum_r + SUM_W'(s_scaled);
                    count_r <= count_r + 1'b1;
                  end
                end else begin
                  mode_r <= (mode_r == MODE_ZERO_CAL) ? MODE_WAIT : MODE_MEASURE;
                  if (count_r == '0) begin
                    guard_r <= 1'b1;
                  end else begin
                    state_r <= ST_DIV_AVG;
                  end
                end
              end
              MODE_WAIT: begin
                if (in_button_pressed) begin
                  mode_r  <= MODE_FULL_CAL;
                  sum_r   <= '0;
                  count_r <= '0;
                end
              end
            endcase
          end
        end
        ST_MUL: begin
          q_neg_r <= diff_neg ^ den_neg_r;
          state_r <= ST_DIV_RAW;
        end
        ST_DIV_RAW: begin
          if (div_done) begin
            raw_r   <= raw_clip;
            sat_r   <= raw_sat;
            state_r <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          acc_neg_r <= acc[ACC_W-1];
          acc_mag_r <= acc_mag;
          state_r   <= ST_TENTH;
        end
        ST_TENTH: begin
          smooth_r <= smooth_q;
          meas_r   <= 1'b1;
          state_r  <= ST_OUT;
        end
        ST_DIV_AVG: begin
          // The mode has already advanced: waiting follows zero calibration.
          if (div_done) begin
            if (mode_r == MODE_WAIT) begin
              zero_ref_r <= div_quo[REF_W-1:0];
            end else begin
              full_ref_r <= div_quo[REF_W-1:0];
            end
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_mode_r   <= mode_r;
            out_raw_r    <= raw_r;
            out_smooth_r <= smooth_r;
            out_meas_r   <= meas_r;
            out_sat_r    <= sat_r;
            out_guard_r  <= guard_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_mode_r;
  assign out_weight_raw      = out_raw_r;
  assign out_weight_smoothed = out_smooth_r;
  assign out_measured        = out_meas_r;
  assign out_saturated       = out_sat_r;
  assign out_divide_guard    = out_guard_r;

endmodule

FILE: rtl/core/tpsc_checker.sv
// Port-level checks for the two-point scale calibrator, bound to its top level.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps

module tpsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] out_weight_raw,
  input logic signed [23:0] out_weight_smoothed,
  input logic               out_measured,
  input logic               out_saturated,
  input logic               out_divide_guard
);

  // Only one item is worked on at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in work");

  // A result without a new weight carries no raw weight and no clipping flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_measured) |-> (out_weight_raw == 24'sd0 && !out_saturated))
    else $error("raw weight or saturation shown without a measurement");

  // Clipping always lands on one of the range limits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_weight_raw == 24'sh7FFFFF || out_weight_raw == 24'sh800000))
    else $error("saturated weight not at a range limit");

  // A blocked division never produces a weight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_measured) |-> !out_divide_guard)
    else $error("weight produced with the divide guard raised");

  // A stalled result holds its smoothed weight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_weight_smoothed)))
    else $error("stalled result changed");

endmodule

bind two_point_scale_calibrator tpsc_checker u_tpsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_weight_raw      (out_weight_raw),
  .out_weight_smoothed (out_weight_smoothed),
  .out_measured        (out_measured),
  .out_saturated       (out_saturated),
  .out_divide_guard    (out_divide_guard)
);
